// File: rtl/nstg_pkg.sv
// nstg_pkg: widths, codes, tune tables and constants for the note sequence tone generator
// no dependencies; imported by note_sequence_tone_generator
package nstg_pkg;

  // default build parameters
  localparam int SAMPLE_RATE_HZ_DEF = 44100;
  localparam int MAX_PERIOD_DEF     = 1024;
  localparam int SINE_ENTRIES_DEF   = 1024;

  // fixed field widths
  localparam int SP_W       = 11;
  localparam int RC_W       = 16;
  localparam int NP_W       = 4;
  localparam int NOTE_W     = 4;
  localparam int TUNE_W     = 2;
  localparam int SMP_W      = 8;
  localparam int LEN_W      = 4;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;
  localparam int POLY_W     = 17;
  localparam int FRAC_W     = 16;

  localparam logic [CFG_DATA_W-1:0] AMPLITUDE_RST = 8'd127;
  localparam logic [CFG_DATA_W-1:0] NOTE_UNIT_RST = 8'd50;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOTE_UNIT = 1'd1;

  // input opcodes and tune selection
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;
  localparam logic [TUNE_W-1:0] SEL_NONE = 2'd3;

  localparam int NUM_TUNES      = 3;
  localparam int NOTES_PER_TUNE = 11;
  localparam int NUM_FREQ       = 10;

  // note frequency in Hz, Q16, for half steps -4..5 from A4
  localparam logic [31:0] FREQ_Q16 [NUM_FREQ] = '{
    32'd22887021, 32'd24247955, 32'd25689813, 32'd27217409, 32'd28835840,
    32'd30550508, 32'd32367136, 32'd34291786, 32'd36330882, 32'd38491228
  };

  typedef logic signed [NOTE_W-1:0] note_t;

  localparam note_t TUNE_NOTES [NUM_TUNES][NOTES_PER_TUNE] = '{
    '{-4'sd1, 4'sd0, -4'sd1, 4'sd0, 4'sd2, 4'sd0, 4'sd5, 4'sd0, 4'sd2, 4'sd0, -4'sd1},
    '{4'sd1, 4'sd0, -4'sd2, 4'sd0, -4'sd2, 4'sd0, -4'sd4, 4'sd0, -4'sd2, 4'sd0, -4'sd2},
    '{4'sd2, 4'sd0, 4'sd0, 4'sd0, 4'sd0, 4'sd0, 4'sd0, 4'sd0, 4'sd0, 4'sd0, 4'sd0}
  };

  localparam logic [LEN_W-1:0] TUNE_LENS [NUM_TUNES][NOTES_PER_TUNE] = '{
    '{4'd6, 4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd9},
    '{4'd6, 4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd9},
    '{4'd4, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0}
  };

  localparam logic [NP_W-1:0] TUNE_COUNT [NUM_TUNES] = '{4'd11, 4'd11, 4'd1};

  // sine polynomial coefficients, Q16, innermost first
  localparam logic [POLY_W-1:0] POLY_COEF [5] = '{
    17'd11, 17'd307, 17'd5223, 17'd42334, 17'd102944
  };
  localparam logic [POLY_W-1:0] S_ONE = 17'd65536;

  // per-tune playback state, kept as one memory word
  typedef struct packed {
    logic              active;
    logic [TUNE_W-1:0] tune_id;
    logic [NP_W-1:0]   note_pos;
    logic [SP_W-1:0]   sample_pos;
    logic [SP_W-1:0]   period_len;
    logic [RC_W-1:0]   repeat_count;
    note_t             current_note;
  } tone_state_t;

endpackage

// File: rtl/note_sequence_tone_generator.sv
// note_sequence_tone_generator: top level of the sine tune player
// depends on nstg_pkg for state layout, tune tables and codes
//
// Plays one of three built-in tunes as a sine wave, one sample per tick item; a start
// item selects the tune (selection 3 stops playback). Items are handled one at a time.
// The playback state sits in a one-word synchronous memory that is read on the input
// transfer and written back when the result is loaded into the output register. A
// start, an idle tick or a tick on a silent note goes from the read state straight to
// the final state, where its result is loaded. A tick on a sounding note runs the
// bit-serial phase divider over DIV_W quotient bits (22 at default parameters). A phase
// of zero or in the negative half ends there and goes to the final state. Otherwise the
// folded phase is scaled to Q16 by a constant reciprocal multiply, a single 17x17
// multiplier steps through the sine polynomial and the amplitude scaling, and the
// result is loaded in the final state. The input is ready again in the
// cycle after a result is loaded, also while that result still waits in the output
// register; a result that is not taken holds back the load of the next one.
// Configuration must be written only while the block is idle; the block does not enforce it.
module note_sequence_tone_generator
  import nstg_pkg::*;
#(
  parameter int SAMPLE_RATE_HZ = SAMPLE_RATE_HZ_DEF,
  parameter int MAX_PERIOD     = MAX_PERIOD_DEF,
  parameter int SINE_ENTRIES   = SINE_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_opcode,
  input  logic [TUNE_W-1:0]     in_song_select,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SMP_W-1:0]      out_sample,
  output logic                  out_playing,
  output logic                  out_done_res
);

  localparam int HALF  = SINE_ENTRIES / 2;
  localparam int QTR   = SINE_ENTRIES / 4;
  localparam int N1_W  = SP_W + $clog2(SINE_ENTRIES + 1);
  localparam int U_W   = $clog2(QTR + 1);
  localparam int N2_W  = U_W + FRAC_W;
  localparam int DIV_W = N1_W;
  localparam int CNT_W = $clog2(DIV_W + 1);

  // reciprocal for the constant quarter-wave division, exact over N2_W-bit numerators
  localparam int RCP_SH = N2_W + $clog2(QTR);
  localparam int RCP_W  = N2_W + 1;
  localparam int PRD_W  = N2_W + RCP_W;
  localparam logic [63:0] RCP_M = ((64'd1 << RCP_SH) + 64'(QTR) - 64'd1) / 64'(QTR);
  localparam logic [RCP_W-1:0] RCP_K = RCP_W'(RCP_M);

  localparam logic [DIV_W-1:0] SINE_K = DIV_W'(SINE_ENTRIES);
  localparam logic [DIV_W-1:0] HALF_K = DIV_W'(HALF);
  localparam logic [DIV_W-1:0] QTR_K  = DIV_W'(QTR);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_W);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_DIV1  = 3'd2;
  localparam logic [2:0] S_SCALE = 3'd3;
  localparam logic [2:0] S_POLY  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  // polynomial steps
  localparam logic [2:0] PS_SQ  = 3'd0;
  localparam logic [2:0] PS_H1  = 3'd1;
  localparam logic [2:0] PS_H2  = 3'd2;
  localparam logic [2:0] PS_H3  = 3'd3;
  localparam logic [2:0] PS_H4  = 3'd4;
  localparam logic [2:0] PS_ST  = 3'd5;
  localparam logic [2:0] PS_AMP = 3'd6;

  function automatic logic [SP_W-1:0] clamp_period(input logic [63:0] p);
    logic [63:0] c;
    c = p;
    if (c < 64'd1) c = 64'd1;
    if (c > 64'(MAX_PERIOD - 1)) c = 64'(MAX_PERIOD - 1);
    return SP_W'(c);
  endfunction

  localparam logic [63:0] RATE_Q16 = 64'(SAMPLE_RATE_HZ) * 64'd65536;

  localparam logic [SP_W-1:0] PERIOD_TAB [NUM_FREQ] = '{
    clamp_period(RATE_Q16 / 64'(FREQ_Q16[0])), clamp_period(RATE_Q16 / 64'(FREQ_Q16[1])),
    clamp_period(RATE_Q16 / 64'(FREQ_Q16[2])), clamp_period(RATE_Q16 / 64'(FREQ_Q16[3])),
    clamp_period(RATE_Q16 / 64'(FREQ_Q16[4])), clamp_period(RATE_Q16 / 64'(FREQ_Q16[5])),
    clamp_period(RATE_Q16 / 64'(FREQ_Q16[6])), clamp_period(RATE_Q16 / 64'(FREQ_Q16[7])),
    clamp_period(RATE_Q16 / 64'(FREQ_Q16[8])), clamp_period(RATE_Q16 / 64'(FREQ_Q16[9]))
  };

  // fetch the note at note_pos and its period; silence keeps the old period
  function automatic tone_state_t load_note(input tone_state_t s);
    tone_state_t       r;
    logic [TUNE_W-1:0] ti;
    logic [NP_W-1:0]   ni;
    logic signed [4:0] idx;
    r   = s;
    ti  = (s.tune_id == SEL_NONE) ? '0 : s.tune_id;
    ni  = (s.note_pos < NP_W'(NOTES_PER_TUNE)) ? s.note_pos : '0;
    r.current_note = TUNE_NOTES[ti][ni];
    idx = {r.current_note[NOTE_W-1], r.current_note} + 5'sd4;
    if (r.current_note != '0 && !idx[4] && idx <= 5'sd9) begin
      r.period_len = PERIOD_TAB[idx[3:0]];
    end
    r.sample_pos = '0;
    return r;
  endfunction

  logic [2:0]            state_r;
  logic [CFG_DATA_W-1:0] amp_r;
  logic [CFG_DATA_W-1:0] unit_r;

  // state memory, one entry
  tone_state_t state_mem [0:0];
  tone_state_t rd_q_r;
  logic        mem_vld_r;
  logic        rd_en;
  logic        wr_en;
  tone_state_t st_rd;

  logic        op_r;
  logic [TUNE_W-1:0] sel_r;
  logic        upd_r;
  tone_state_t cur_r;
  tone_state_t start_s;

  // divider
  logic [DIV_W-1:0] dv_num_r;
  logic [SP_W-1:0]  dv_rem_r;
  logic [SP_W-1:0]  dv_den_r;
  logic [CNT_W-1:0] dv_cnt_r;
  logic [SP_W:0]    dv_trial;
  logic             dv_ge;
  logic [SP_W-1:0]  dv_rem_nxt;
  logic [U_W-1:0]   u_val;

  // quarter-wave scaling
  logic [U_W-1:0]   u_r;
  logic [N2_W-1:0]  sc_num;
  logic [PRD_W-1:0] sc_prod;

  // polynomial
  logic [2:0]          poly_cnt_r;
  logic [POLY_W-1:0]   t_r;
  logic [POLY_W-1:0]   t2_r;
  logic [POLY_W-1:0]   r_r;
  logic [POLY_W-1:0]   s_r;
  logic [POLY_W-1:0]   mul_a;
  logic [POLY_W-1:0]   mul_b;
  logic [2*POLY_W-1:0] mul_p;
  logic [POLY_W-1:0]   prod_hi;
  logic [SMP_W-1:0]    smp_r;

  // tick update
  tone_state_t       fin_s;
  logic              fin_done;
  logic [SP_W-1:0]   sp1;
  logic [RC_W-1:0]   rc1;
  logic [NP_W-1:0]   np1;
  logic [TUNE_W-1:0] tsel;
  logic [NP_W-1:0]   nsel;
  logic [RC_W-1:0]   limit;
  logic              out_free;

  logic              out_valid_r;
  logic [SMP_W-1:0]  out_sample_r;
  logic              out_playing_r;
  logic              out_done_r;

  assign in_ready     = (state_r == S_IDLE);
  assign rd_en        = in_valid && in_ready;
  assign out_free     = !out_valid_r || out_ready;
  assign wr_en        = (state_r == S_FIN) && out_free;
  assign st_rd        = mem_vld_r ? rd_q_r : '0;

  assign out_valid    = out_valid_r;
  assign out_sample   = out_sample_r;
  assign out_playing  = out_playing_r;
  assign out_done_res = out_done_r;

  always_ff @(posedge clk) begin
    if (rd_en) rd_q_r <= state_mem[0];
    if (wr_en) state_mem[0] <= fin_s;
  end

  // start: restart the selected tune, or stop on the empty selection
  always_comb begin
    start_s = st_rd;
    if (sel_r != SEL_NONE) begin
      start_s.tune_id      = sel_r;
      start_s.note_pos     = '0;
      start_s.repeat_count = '0;
      start_s              = load_note(start_s);
      start_s.active       = 1'b1;
    end else begin
      start_s.active = 1'b0;
    end
  end

  // restoring divider, one quotient bit per cycle
  assign dv_trial   = {dv_rem_r, dv_num_r[DIV_W-1]};
  assign dv_ge      = (dv_trial >= {1'b0, dv_den_r});
  assign dv_rem_nxt = dv_ge ? SP_W'(dv_trial - {1'b0, dv_den_r}) : SP_W'(dv_trial);
  assign u_val      = (dv_num_r < QTR_K) ? U_W'(dv_num_r) : U_W'(HALF_K - dv_num_r);

  assign sc_num  = N2_W'(u_r) << FRAC_W;
  assign sc_prod = PRD_W'(sc_num) * PRD_W'(RCP_K);

  always_comb begin
    mul_a = t_r;
    mul_b = t_r;
    unique case (poly_cnt_r)
      PS_SQ: begin
        mul_a = t_r;
        mul_b = t_r;
      end
      PS_H1: begin
        mul_a = POLY_COEF[0];
        mul_b = t2_r;
      end
      PS_H2, PS_H3, PS_H4: begin
        mul_a = r_r;
        mul_b = t2_r;
      end
      PS_ST: begin
        mul_a = r_r;
        mul_b = t_r;
      end
      PS_AMP: begin
        mul_a = POLY_W'(amp_r);
        mul_b = s_r;
      end
      default: begin
        mul_a = t_r;
        mul_b = t_r;
      end
    endcase
  end

  assign mul_p   = (2*POLY_W)'(mul_a) * (2*POLY_W)'(mul_b);
  assign prod_hi = POLY_W'(mul_p >> FRAC_W);

  assign sp1   = cur_r.sample_pos + SP_W'(1);
  assign rc1   = cur_r.repeat_count + RC_W'(1);
  assign np1   = cur_r.note_pos + NP_W'(1);
  assign tsel  = (cur_r.tune_id == SEL_NONE) ? '0 : cur_r.tune_id;
  assign nsel  = (cur_r.note_pos < NP_W'(NOTES_PER_TUNE)) ? cur_r.note_pos : '0;
  assign limit = RC_W'(TUNE_LENS[tsel][nsel]) * RC_W'(unit_r);

  // period wrap, note advance and end of tune
  always_comb begin
    fin_s    = cur_r;
    fin_done = 1'b0;
    if (upd_r) begin
      if (sp1 >= cur_r.period_len) begin
        if (rc1 < limit) begin
          fin_s.sample_pos   = '0;
          fin_s.repeat_count = rc1;
        end else begin
          fin_s.repeat_count = '0;
          if (np1 < TUNE_COUNT[tsel]) begin
            fin_s.note_pos = np1;
            fin_s          = load_note(fin_s);
          end else begin
            fin_s.note_pos   = '0;
            fin_s.sample_pos = '0;
            fin_s.active     = 1'b0;
            fin_done         = 1'b1;
          end
        end
      end else begin
        fin_s.sample_pos = sp1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amp_r  <= AMPLITUDE_RST;
      unit_r <= NOTE_UNIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_AMPLITUDE: amp_r  <= cfg_wdata;
        CFG_NOTE_UNIT: unit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_vld_r <= 1'b0;
    end else if (wr_en) begin
      mem_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // a load in S_FIN takes precedence over the transfer of the old result
      if (out_ready && !wr_en) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (rd_en) begin
            op_r    <= in_opcode;
            sel_r   <= in_song_select;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          smp_r <= '0;
          upd_r <= (op_r == OP_TICK) && st_rd.active;
          if (op_r == OP_START) begin
            cur_r   <= start_s;
            state_r <= S_FIN;
          end else begin
            cur_r <= st_rd;
            if (st_rd.active && st_rd.current_note != '0 && st_rd.period_len != '0) begin
              dv_num_r <= DIV_W'(st_rd.sample_pos) * SINE_K;
              dv_den_r <= st_rd.period_len;
              dv_rem_r <= '0;
              dv_cnt_r <= '0;
              state_r  <= S_DIV1;
            end else begin
              state_r <= S_FIN;
            end
          end
        end
        S_DIV1: begin
          if (dv_cnt_r != DIV_LAST) begin
            dv_num_r <= {dv_num_r[DIV_W-2:0], dv_ge};
            dv_rem_r <= dv_rem_nxt;
            dv_cnt_r <= dv_cnt_r + CNT_W'(1);
          end else if (dv_num_r == '0 || dv_num_r >= HALF_K) begin
            state_r <= S_FIN;
          end else begin
            u_r     <= u_val;
            state_r <= S_SCALE;
          end
        end
        S_SCALE: begin
          // scale the folded phase to Q16 over a quarter wave
          t_r        <= POLY_W'(sc_prod >> RCP_SH);
          poly_cnt_r <= PS_SQ;
          state_r    <= S_POLY;
        end
        S_POLY: begin
          poly_cnt_r <= poly_cnt_r + 3'd1;
          unique case (poly_cnt_r)
            PS_SQ:               t2_r <= prod_hi;
            PS_H1, PS_H2, PS_H3, PS_H4: r_r <= POLY_COEF[poly_cnt_r] - prod_hi;
            PS_ST:               s_r  <= (prod_hi > S_ONE) ? S_ONE : prod_hi;
            PS_AMP: begin
              smp_r   <= (prod_hi > POLY_W'(255)) ? SMP_W'(255) : SMP_W'(prod_hi);
              state_r <= S_FIN;
            end
            default: state_r <= S_FIN;
          endcase
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r   <= 1'b1;
            out_sample_r  <= smp_r;
            out_playing_r <= fin_s.active;
            out_done_r    <= fin_done;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/nstg_checker.sv
// nstg_checker: port-level assertions for note_sequence_tone_generator
// bound to the top level below; no package dependencies
module nstg_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_sample,
  input logic       out_playing,
  input logic       out_done_res
);

  // nothing is offered in the cycle after reset
  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // the end-of-tune result never reports the tune as still playing
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_playing)
    else $error("done raised while playing");

  // idle results are silent; only the final tick may carry a sample
  a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_playing && !out_done_res |-> out_sample == 8'd0)
    else $error("nonzero sample while idle");

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_sample) && $stable(out_playing)
      && $stable(out_done_res))
    else $error("result changed while stalled");

endmodule

bind note_sequence_tone_generator nstg_checker u_nstg_checker (.*);
